// File: sv/pcss_pkg.sv
// ----------------------------------------------------------------------------
// pcss_pkg: shared types and codes for the pixel coverage and seam stats unit
// Beat payloads, the seam cell control and accumulator structs, and the codes
// for opcodes, classes, record kinds and configuration indexes.
// ----------------------------------------------------------------------------
package pcss_pkg;

  // opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // diagnostic classes
  localparam logic [7:0] CLASS_OK    = 8'd1;
  localparam logic [7:0] CLASS_MULTI = 8'd4;
  localparam logic [7:0] CLASS_SYNTH = 8'd7;

  // record kinds
  localparam logic REC_TOTALS = 1'b0;
  localparam logic REC_SEAM   = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_FRAME_WIDTH    = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT   = 2'd1;
  localparam logic [1:0] CFG_DARK_THRESHOLD = 2'd2;
  localparam logic [1:0] CFG_SEAM_COUNT     = 2'd3;

  localparam logic [12:0] RST_FRAME_WIDTH    = 13'd4096;
  localparam logic [12:0] RST_FRAME_HEIGHT   = 13'd4096;
  localparam logic [8:0]  RST_DARK_THRESHOLD = 9'd40;
  localparam logic [4:0]  RST_SEAM_COUNT     = 5'd0;

  typedef struct packed {
    logic        opcode;
    logic [3:0]  seam_slot;
    logic [11:0] seam_column;
    logic [7:0]  pixel_value;
    logic [7:0]  pixel_class;
  } pcss_in_t;

  typedef struct packed {
    logic        record_kind;
    logic [24:0] covered_count;
    logic [24:0] multi_count;
    logic [24:0] dark_count;
    logic [24:0] synth_count;
    logic [25:0] baseline_sum;
    logic [17:0] baseline_pairs;
    logic [3:0]  seam_index;
    logic [19:0] seam_sum;
    logic [12:0] seam_pairs;
    logic        seam_enough;
    logic        last;
  } pcss_out_t;

  // one seam cell's accumulators
  typedef struct packed {
    logic [20:0] sum;
    logic [12:0] pairs;
  } pcss_acc_t;

  // broadcast to every seam cell
  typedef struct packed {
    logic        evt_valid;  // covered pair whose left column fits 12 bits
    logic [11:0] col;        // left column of the pair
    logic [7:0]  diff;       // absolute intensity difference
    logic        shift;      // take the right neighbor's accumulators
    logic        clr;        // zero the accumulators
  } pcss_cell_ctl_t;

endpackage

// File: sv/pixel_coverage_seam_stats_unit.sv
// ----------------------------------------------------------------------------
// pixel_coverage_seam_stats_unit: frame coverage and seam difference stats
// Counts covered, multi, dark and synthetic pixels of a raster stream, sums
// neighbor differences at baseline and loaded seam columns, and reports at
// frame end.
// ----------------------------------------------------------------------------
// Pixels and seam loads are taken one beat per cycle. The pixel that closes a
// frame emits a totals record and, with n seam slots in use, n seam records
// follow one per cycle as the output drains; the input stalls while they are
// issued and the seam cell chain shifts its accumulators to the head, and
// the chain clears as the last record leaves. A closing pixel also stalls
// while a record of the previous report still waits at the output.
// ----------------------------------------------------------------------------
module pixel_coverage_seam_stats_unit #(
  parameter int MAX_SEAMS   = 16,
  parameter int MAX_WIDTH   = 4096,
  parameter int MAX_HEIGHT  = 4096,
  parameter int BASE_STRIDE = 97
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pcss_pkg::pcss_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pcss_pkg::pcss_out_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [12:0]         cfg_data
);
  import pcss_pkg::*;

  localparam int PW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int SW = $clog2(BASE_STRIDE);
  localparam int CW = $clog2(MAX_SEAMS + 1);
  localparam int NW = (CW > 5) ? CW : 5;

  // configuration
  logic [12:0] cfg_width_r;
  logic [12:0] cfg_height_r;
  logic [8:0]  cfg_thr_r;
  logic [4:0]  cfg_seams_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= RST_FRAME_WIDTH;
      cfg_height_r <= RST_FRAME_HEIGHT;
      cfg_thr_r    <= RST_DARK_THRESHOLD;
      cfg_seams_r  <= RST_SEAM_COUNT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:    cfg_width_r  <= cfg_data;
        CFG_FRAME_HEIGHT:   cfg_height_r <= cfg_data;
        CFG_DARK_THRESHOLD: cfg_thr_r    <= cfg_data[8:0];
        CFG_SEAM_COUNT:     cfg_seams_r  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [NW-1:0] n_eff;

  always_comb begin
    if (cfg_width_r < 13'd2) begin
      w_eff = WW'(2);
    end else if (32'(cfg_width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_width_r);
    end
    if (cfg_height_r < 13'd1) begin
      h_eff = HW'(1);
    end else if (32'(cfg_height_r) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(cfg_height_r);
    end
    if (32'(cfg_seams_r) > MAX_SEAMS) begin
      n_eff = NW'(MAX_SEAMS);
    end else begin
      n_eff = NW'(cfg_seams_r);
    end
  end

  // frame state
  logic [PW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [SW-1:0] phase_r;
  logic [7:0]    prev_val_r;
  logic [7:0]    prev_cls_r;
  logic [24:0]   cov_r, multi_r, dark_r, synth_r;
  logic [25:0]   bl_sum_r;
  logic [17:0]   base_cnt_r;
  logic [24:0]   cov_nxt, multi_nxt, dark_nxt, synth_nxt;
  logic [25:0]   bl_sum_nxt;
  logic [17:0]   base_cnt_nxt;
  logic [26:0]   bl_sum_ext;

  logic          out_valid_r;
  pcss_out_t     out_data_r;
  logic          rpt_r;
  logic [NW-1:0] rpt_idx_r;
  logic          rpt_last;
  logic          out_free;

  logic          end_of_row, end_of_frame;
  logic          in_acc, pix, load;
  logic          cur_cov, prev_cov;
  logic [7:0]    diff;
  logic          pair, base_hit;
  logic [PW-1:0] xm1;
  logic [SW-1:0] phase_nxt;

  assign end_of_row   = (32'(col_r) + 32'd1) >= 32'(w_eff);
  assign end_of_frame = end_of_row && ((32'(row_r) + 32'd1) >= 32'(h_eff));

  // hold every beat during the seam readout, and a closing pixel while the output still carries a record
  assign in_stall = rpt_r || (out_valid_r && end_of_frame);
  assign in_acc   = in_valid && !in_stall;
  assign pix      = in_acc && (in_data.opcode == OP_PIXEL);
  assign load     = in_acc && (in_data.opcode == OP_LOAD);

  assign cur_cov  = (in_data.pixel_class == CLASS_OK) || (in_data.pixel_class == CLASS_MULTI);
  assign prev_cov = (prev_cls_r == CLASS_OK) || (prev_cls_r == CLASS_MULTI);
  assign diff     = (in_data.pixel_value >= prev_val_r) ? in_data.pixel_value - prev_val_r
                                                        : prev_val_r - in_data.pixel_value;
  assign pair     = pix && (col_r != '0) && cur_cov && prev_cov;
  assign base_hit = pair && (32'(col_r) >= 32'd2) && (phase_r == '0);
  assign xm1      = col_r - PW'(1);

  always_comb begin
    if (32'(col_r) <= 32'd1) begin
      phase_nxt = '0;
    end else if ((32'(phase_r) + 32'd1) >= BASE_STRIDE) begin
      phase_nxt = '0;
    end else begin
      phase_nxt = phase_r + SW'(1);
    end
  end

  assign bl_sum_ext = {1'b0, bl_sum_r} + {19'd0, diff};

  always_comb begin
    cov_nxt      = cov_r;
    multi_nxt    = multi_r;
    dark_nxt     = dark_r;
    synth_nxt    = synth_r;
    bl_sum_nxt   = bl_sum_r;
    base_cnt_nxt = base_cnt_r;
    if (pix) begin
      if (in_data.pixel_class == CLASS_SYNTH) begin
        synth_nxt = (&synth_r) ? synth_r : synth_r + 25'd1;
      end else if (cur_cov) begin
        cov_nxt = (&cov_r) ? cov_r : cov_r + 25'd1;
        if (in_data.pixel_class == CLASS_MULTI) begin
          multi_nxt = (&multi_r) ? multi_r : multi_r + 25'd1;
        end
        if ({1'b0, in_data.pixel_value} < cfg_thr_r) begin
          dark_nxt = (&dark_r) ? dark_r : dark_r + 25'd1;
        end
      end
    end
    if (base_hit) begin
      bl_sum_nxt   = bl_sum_ext[26] ? {26{1'b1}} : bl_sum_ext[25:0];
      base_cnt_nxt = (&base_cnt_r) ? base_cnt_r : base_cnt_r + 18'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      phase_r    <= '0;
      prev_val_r <= '0;
      prev_cls_r <= '0;
      cov_r      <= '0;
      multi_r    <= '0;
      dark_r     <= '0;
      synth_r    <= '0;
      bl_sum_r   <= '0;
      base_cnt_r <= '0;
    end else if (pix) begin
      if (end_of_frame) begin
        // clear the frame; totals leave through the output register
        col_r      <= '0;
        row_r      <= '0;
        phase_r    <= '0;
        prev_val_r <= '0;
        prev_cls_r <= '0;
        cov_r      <= '0;
        multi_r    <= '0;
        dark_r     <= '0;
        synth_r    <= '0;
        bl_sum_r   <= '0;
        base_cnt_r <= '0;
      end else begin
        phase_r    <= phase_nxt;
        prev_val_r <= in_data.pixel_value;
        prev_cls_r <= in_data.pixel_class;
        cov_r      <= cov_nxt;
        multi_r    <= multi_nxt;
        dark_r     <= dark_nxt;
        synth_r    <= synth_nxt;
        bl_sum_r   <= bl_sum_nxt;
        base_cnt_r <= base_cnt_nxt;
        if (end_of_row) begin
          col_r <= '0;
          row_r <= row_r + RW'(1);
        end else begin
          col_r <= col_r + PW'(1);
        end
      end
    end
  end

  // seam cell chain
  pcss_cell_ctl_t cell_ctl;
  pcss_acc_t      acc [MAX_SEAMS];

  assign out_free = !out_valid_r || !out_stall;
  assign rpt_last = (rpt_idx_r + NW'(1)) == n_eff;

  always_comb begin
    cell_ctl.evt_valid = pair && (32'(xm1) < 32'd4096);
    cell_ctl.col       = 12'(xm1);
    cell_ctl.diff      = diff;
    cell_ctl.shift     = rpt_r && out_free && !rpt_last;
    cell_ctl.clr       = (rpt_r && out_free && rpt_last) ||
                         (pix && end_of_frame && (n_eff == '0));
  end

  for (genvar k = 0; k < MAX_SEAMS; k++) begin : g_cell
    pcss_acc_t nbr;
    if (k == MAX_SEAMS - 1) begin : g_tail
      assign nbr = '0;
    end else begin : g_link
      assign nbr = acc[k + 1];
    end
    pcss_seam_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (cell_ctl),
      .en        (NW'(k) < n_eff),
      .col_we    (load && (32'(in_data.seam_slot) == k)),
      .col_wdata (in_data.seam_column),
      .nbr_acc   (nbr),
      .acc       (acc[k])
    );
  end

  // report sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      rpt_r       <= 1'b0;
      rpt_idx_r   <= '0;
    end else if (pix && end_of_frame) begin
      out_valid_r <= 1'b1;
      rpt_r       <= (n_eff != '0);
      rpt_idx_r   <= '0;
    end else if (rpt_r && out_free) begin
      out_valid_r <= 1'b1;
      rpt_idx_r   <= rpt_idx_r + NW'(1);
      if (rpt_last) begin
        rpt_r <= 1'b0;
      end
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  pcss_out_t tot_rec, seam_rec;

  always_comb begin
    tot_rec                = '0;
    tot_rec.record_kind    = REC_TOTALS;
    tot_rec.covered_count  = cov_nxt;
    tot_rec.multi_count    = multi_nxt;
    tot_rec.dark_count     = dark_nxt;
    tot_rec.synth_count    = synth_nxt;
    tot_rec.baseline_sum   = bl_sum_nxt;
    tot_rec.baseline_pairs = base_cnt_nxt;
    tot_rec.last           = (n_eff == '0);

    seam_rec               = '0;
    seam_rec.record_kind   = REC_SEAM;
    seam_rec.seam_index    = 4'(rpt_idx_r);
    seam_rec.seam_sum      = acc[0].sum[19:0];
    seam_rec.seam_pairs    = acc[0].pairs;
    seam_rec.seam_enough   = 32'(acc[0].pairs) >= 32'(h_eff >> 3);
    seam_rec.last          = rpt_last;
  end

  always_ff @(posedge clk) begin
    if (pix && end_of_frame) begin
      out_data_r <= tot_rec;
    end else if (rpt_r && out_free) begin
      out_data_r <= seam_rec;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: sv/pcss_seam_cell.sv
// ----------------------------------------------------------------------------
// pcss_seam_cell: one seam slot of the cell chain
// Holds a seam column with its difference sum and pair count. Accumulates on
// a matching pair, and shifts its accumulators toward the chain head during
// the end-of-frame readout.
// ----------------------------------------------------------------------------
module pcss_seam_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  pcss_pkg::pcss_cell_ctl_t ctl,
  input  logic                    en,
  input  logic                    col_we,
  input  logic [11:0]             col_wdata,
  input  pcss_pkg::pcss_acc_t     nbr_acc,
  output pcss_pkg::pcss_acc_t     acc
);
  import pcss_pkg::*;

  logic [11:0] column_r;
  pcss_acc_t   acc_r;
  pcss_acc_t   acc_nxt;
  logic        hit;
  logic [21:0] sum_ext;

  assign hit     = ctl.evt_valid && en && (column_r == ctl.col);
  assign sum_ext = {1'b0, acc_r.sum} + {14'd0, ctl.diff};

  always_comb begin
    acc_nxt = acc_r;
    priority if (ctl.clr) begin
      acc_nxt = '0;
    end else if (ctl.shift) begin
      acc_nxt = nbr_acc;
    end else if (hit) begin
      acc_nxt.sum   = sum_ext[21] ? {21{1'b1}} : sum_ext[20:0];
      acc_nxt.pairs = (&acc_r.pairs) ? acc_r.pairs : acc_r.pairs + 13'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  // column survives frame clears; no reset
  always_ff @(posedge clk) begin
    if (col_we) begin
      column_r <= col_wdata;
    end
  end

  assign acc = acc_r;

endmodule
